// ===== sv/eilc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eilc_pkg: shared types and constants of the external interrupt line block
// Word formats, request and trigger codes, register offsets and bit fields.
// ----------------------------------------------------------------------------
package eilc_pkg;

   localparam int NUM_LINES  = 3;
   localparam int LINE_SLOTS = 3;

   typedef enum logic [1:0] {
      REQ_READ  = 2'd0,
      REQ_WRITE = 2'd1,
      REQ_TICK  = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      TRIG_HIGH = 2'd0,
      TRIG_LOW  = 2'd1,
      TRIG_RISE = 2'd2,
      TRIG_FALL = 2'd3
   } trig_type;

   typedef struct packed {
      req_kind_type req_type;
      logic [11:0]  reg_offset;
      logic [31:0]  write_data;
      logic [2:0]   pin_levels;
   } req_word_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [2:0]  irq_lines;
      logic        addr_error;
   } rsp_word_type;

   // Per-line stored state
   typedef struct packed {
      trig_type trig;
      logic     enable;
      logic     clk_sel;
      logic     pending;
      logic     prev_level;
   } line_state_type;

   // Control from the pipeline to the line logic
   typedef struct packed {
      logic commit;
      logic layout;
   } line_ctl_type;

   // Register offsets
   localparam logic [11:0] OFF_LINE0 = 12'h200;
   localparam logic [11:0] OFF_LINE1 = 12'h528;
   localparam logic [11:0] OFF_LINE2 = 12'h52C;
   localparam logic [11:0] SPLIT_OFFSETS [LINE_SLOTS] = '{OFF_LINE0, OFF_LINE1, OFF_LINE2};

   // Control byte bit positions
   localparam int CTL_PEND_BIT  = 0;
   localparam int CTL_CLK_BIT   = 4;
   localparam int CTL_EN_BIT    = 5;
   localparam int CTL_TYPE_LSB  = 6;

   // Configuration register map
   localparam logic [2:0] CSR_ADDR_LAYOUT = 3'd0;

   function automatic logic [7:0] ctl_byte(input line_state_type s);
      logic [7:0] b;
      b = 8'h00;
      b[CTL_PEND_BIT] = s.pending;
      b[CTL_CLK_BIT]  = s.clk_sel;
      b[CTL_EN_BIT]   = s.enable;
      b[CTL_TYPE_LSB +: 2] = s.trig;
      return b;
   endfunction

endpackage

// ===== sv/eilc_lines.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eilc_lines: line state and per-item update
// Decodes register accesses, samples pins on ticks and forms the result word.
// ----------------------------------------------------------------------------
module eilc_lines (
   input  logic                  clock,
   input  logic                  reset,
   input  eilc_pkg::line_ctl_type ctl,
   input  eilc_pkg::req_word_type item,
   output eilc_pkg::rsp_word_type result
);

   eilc_pkg::line_state_type line_ff [eilc_pkg::LINE_SLOTS];
   eilc_pkg::line_state_type line_in [eilc_pkg::LINE_SLOTS];

   logic [eilc_pkg::LINE_SLOTS-1:0] sel;
   logic                            is_access;
   logic                            hit;
   logic [7:0]                      wr_byte [eilc_pkg::LINE_SLOTS];
   logic [31:0]                     rd_data;
   logic                            now_lvl;
   logic                            trig_hit;

   always_comb begin
      is_access = (item.req_type == eilc_pkg::REQ_READ) ||
                  (item.req_type == eilc_pkg::REQ_WRITE);
      hit     = 1'b0;
      rd_data = 32'h0;
      now_lvl = 1'b0;
      trig_hit = 1'b0;
      for (int i = 0; i < eilc_pkg::LINE_SLOTS; i++) begin
         if (ctl.layout) begin
            sel[i]     = (i < eilc_pkg::NUM_LINES) && (item.reg_offset == eilc_pkg::OFF_LINE0);
            wr_byte[i] = item.write_data[(2 - i) * 8 +: 8];
         end else begin
            sel[i]     = (i < eilc_pkg::NUM_LINES) &&
                         (item.reg_offset == eilc_pkg::SPLIT_OFFSETS[i]);
            wr_byte[i] = item.write_data[7:0];
         end
      end
      if (ctl.layout) begin
         hit = (item.reg_offset == eilc_pkg::OFF_LINE0);
         for (int i = 0; i < eilc_pkg::LINE_SLOTS; i++) begin
            if (sel[i]) begin
               rd_data[(2 - i) * 8 +: 8] = eilc_pkg::ctl_byte(line_ff[i]);
            end
         end
      end else begin
         hit = |sel;
         for (int i = 0; i < eilc_pkg::LINE_SLOTS; i++) begin
            if (sel[i]) begin
               rd_data[7:0] = eilc_pkg::ctl_byte(line_ff[i]);
            end
         end
      end

      for (int i = 0; i < eilc_pkg::LINE_SLOTS; i++) begin
         line_in[i] = line_ff[i];
         case (item.req_type)
            eilc_pkg::REQ_WRITE: begin
               if (sel[i]) begin
                  line_in[i].clk_sel = wr_byte[i][eilc_pkg::CTL_CLK_BIT];
                  line_in[i].enable  = wr_byte[i][eilc_pkg::CTL_EN_BIT];
                  line_in[i].trig    =
                     eilc_pkg::trig_type'(wr_byte[i][eilc_pkg::CTL_TYPE_LSB +: 2]);
                  if (wr_byte[i][eilc_pkg::CTL_PEND_BIT]) begin
                     line_in[i].pending = 1'b0;
                  end
               end
            end
            eilc_pkg::REQ_TICK: begin
               if (i < eilc_pkg::NUM_LINES) begin
                  now_lvl = item.pin_levels[i];
                  case (line_ff[i].trig)
                     eilc_pkg::TRIG_HIGH: trig_hit = now_lvl;
                     eilc_pkg::TRIG_LOW:  trig_hit = !now_lvl;
                     eilc_pkg::TRIG_RISE: trig_hit = !line_ff[i].prev_level && now_lvl;
                     eilc_pkg::TRIG_FALL: trig_hit = line_ff[i].prev_level && !now_lvl;
                     default:             trig_hit = 1'b0;
                  endcase
                  if (line_ff[i].enable && trig_hit) begin
                     line_in[i].pending = 1'b1;
                  end
                  line_in[i].prev_level = now_lvl;
               end
            end
            default: begin
            end
         endcase
      end

      result.read_data  = (item.req_type == eilc_pkg::REQ_READ) ? rd_data : 32'h0;
      result.addr_error = is_access && !hit;
      for (int i = 0; i < eilc_pkg::LINE_SLOTS; i++) begin
         result.irq_lines[i] = (i < eilc_pkg::NUM_LINES) &&
                               line_in[i].pending && line_in[i].enable;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < eilc_pkg::LINE_SLOTS; i++) begin
         if (reset) begin
            line_ff[i] <= '0;
         end else if (ctl.commit) begin
            line_ff[i] <= line_in[i];
         end
      end
   end

endmodule

// ===== sv/external_irq_line_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// external_irq_line_controller: three external interrupt lines
// Path: a word accepted into the input register passes through the line logic,
// and its result is registered in the output register, which drives rsp_data.
// Throughput: one word per cycle unless the response stalls; the input register
// feeds the line logic, whose result lands in the output register in the same cycle.
// Reset (synchronous): all lines disabled, high type, nothing pending,
// previous pin levels low, split register layout.
// ----------------------------------------------------------------------------
module external_irq_line_controller (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  eilc_pkg::req_word_type req_data,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output eilc_pkg::rsp_word_type rsp_data,
   // configuration port
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [2:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   // Input stage
   logic                   in_valid_ff;
   logic                   in_valid_in;
   eilc_pkg::req_word_type in_word_ff;

   // Output stage
   logic                   out_valid_ff;
   logic                   out_valid_in;
   eilc_pkg::rsp_word_type out_word_ff;

   logic                   layout_ff;
   logic                   out_free;
   logic                   advance;
   logic                   take_in;
   eilc_pkg::line_ctl_type line_ctl;
   eilc_pkg::rsp_word_type result;

   // The output register frees up when empty or when its word leaves now.
   assign out_free  = !out_valid_ff || !rsp_stall;
   // Move the held word through the line logic into the output register.
   assign advance   = in_valid_ff && out_free;
   // Hold off the sender only while the input stage is full and cannot move.
   assign req_stall = in_valid_ff && !out_free;
   assign take_in   = req_valid && !req_stall;

   assign in_valid_in  = take_in || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers: load on accept, hold otherwise.
   always_ff @(posedge clock) begin
      if (take_in) begin
         in_word_ff <= req_data;
      end
      if (advance) begin
         out_word_ff <= result;
      end
   end

   // Line state commits exactly when a word advances.
   assign line_ctl.commit = advance;
   assign line_ctl.layout = layout_ff;

   eilc_lines u_lines (
      .clock  (clock),
      .reset  (reset),
      .ctl    (line_ctl),
      .item   (in_word_ff),
      .result (result)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_word_ff;

   // Configuration: single layout register, no wait states.
   assign pready = 1'b1;
   assign prdata = (paddr == eilc_pkg::CSR_ADDR_LAYOUT) ? {31'h0, layout_ff} : 32'h0;

   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff <= 1'b0;
      end else if (psel && penable && pwrite && pready &&
                   (paddr == eilc_pkg::CSR_ADDR_LAYOUT)) begin
         layout_ff <= pwdata[0];
      end
   end

endmodule
